// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by timed_event_min_heap_top, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tehp_pkg.sv
// ----------------------------------------------------------------------------
// tehp_pkg
// shared types and constants of the timed event heap
// ----------------------------------------------------------------------------
package tehp_pkg;

    localparam int TIME_W    = 64;
    localparam int ID_PORT_W = 8;
    localparam int MAX_OUT   = 32;
    localparam int OUT_CNT_W = 6;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP      = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_RESCHED  = 3'd3,
        CMD_CHANGE   = 3'd4,
        CMD_DELAY    = 3'd5,
        CMD_HASTEN   = 3'd6,
        CMD_RUN_DUE  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_NONE_DUE  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CK,
        S_DISPATCH,
        S_INS,
        S_UP_RD,
        S_UP_CK,
        S_DN_RD0,
        S_DN_RD1,
        S_DN_CK,
        S_DN_MV,
        S_POP_RD,
        S_POP_LAST,
        S_POP_ELEM,
        S_REM_RD,
        S_REM_GO,
        S_DUE_RD,
        S_DUE_CK,
        S_EMIT
    } t_state;

endpackage

// File: rtl/timed_event_min_heap_top.sv
// ----------------------------------------------------------------------------
// timed_event_min_heap_top
// binary min-heap event queue driven by a small sequencer over one slot ram
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the in channel (i_in_valid/o_in_ready)
// and one or more result beats leave on the out channel (o_out_valid/
// i_out_ready); o_last marks the final result of a command. Run-due gives up
// to 32 results, every other command gives exactly one.
// The sequencer works on one command at a time and o_in_ready is high only
// while it is idle. Every heap step goes through the single slot ram
// (one read or write a cycle) and one shared 64-bit comparator: insert
// climbs the heap level by level, pop descends it level by level, and id
// searches step through the stored entries one by one. Run-due pops and
// re-sifts the heap for every event it emits, up to 32 events.
// Results sit in an output register; the sequencer goes back to idle as soon
// as the final result is loaded, and a stalled receiver only holds the
// sequencer when a further result has to be loaded.
// Reset empties the heap (count to zero) and drops any pending result; the
// slot contents are not cleared, slots beyond the count are never read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_event_min_heap_top #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_cmd,
    input  logic [7:0]                i_event_id,
    input  logic [tehp_pkg::TIME_W-1:0] i_time_value,
    input  logic [tehp_pkg::TIME_W-1:0] i_event_time_in,
    input  logic [tehp_pkg::TIME_W-1:0] i_now_time,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [7:0]                o_out_event_id,
    output logic [tehp_pkg::TIME_W-1:0] o_event_time,
    output logic [2:0]                o_status,
    output logic                      o_last
);

    import tehp_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = IDX_W + 2;
    localparam int EW    = ID_BITS + TIME_W;

    // state and registers
    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [TIME_W-1:0]    r_time, n_time;
    logic [TIME_W-1:0]    r_old, n_old;
    logic [TIME_W-1:0]    r_now, n_now;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_scan, n_scan;
    logic                 r_found, n_found;
    logic [TIME_W-1:0]    r_ftime, n_ftime;
    logic [EW-1:0]        r_elem, n_elem;
    logic [IDX_W-1:0]     r_i, n_i;
    logic                 r_resift, n_resift;
    logic                 r_inserted, n_inserted;
    logic [EW-1:0]        r_ca, n_ca;
    logic                 r_two, n_two;
    logic [EW-1:0]        r_child, n_child;
    logic [IDX_W-1:0]     r_ci, n_ci;
    logic [ID_BITS-1:0]   r_res_id, n_res_id;
    logic [TIME_W-1:0]    r_res_time, n_res_time;
    t_status              r_res_st, n_res_st;
    logic [OUT_CNT_W-1:0] r_n, n_n;
    logic                 r_o_valid, n_o_valid;
    logic [7:0]           r_o_id, n_o_id;
    logic [TIME_W-1:0]    r_o_time, n_o_time;
    t_status              r_o_st, n_o_st;
    logic                 r_o_last, n_o_last;

    // ram port
    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, rd;

    // shared signals
    logic [TIME_W-1:0]    rd_t, cmp_a, cmp_b;
    logic [ID_BITS-1:0]   rd_id;
    logic                 lt, can_emit, c_ge, c1_lt, full, rem_inside, due_stop;
    logic [CW-1:0]        c_ext, c1_ext, cnt_ext;
    logic [IDX_W-1:0]     parent, c_idx, c1_idx, last_idx;
    logic [TIME_W-1:0]    base_t, new_t;
    logic [TIME_W:0]      sum_t, diff_t;
    t_state               done_next;

    tehp_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign rd_t  = rd[TIME_W-1:0];
    assign rd_id = rd[EW-1:TIME_W];

    // index arithmetic
    assign parent     = IDX_W'((r_i - 1'b1) >> 1);
    assign c_ext      = CW'({r_i, 1'b1});
    assign c1_ext     = c_ext + 1'b1;
    assign cnt_ext    = CW'(r_cnt);
    assign c_ge       = (c_ext >= cnt_ext);
    assign c1_lt      = (c1_ext < cnt_ext);
    assign c_idx      = c_ext[IDX_W-1:0];
    assign c1_idx     = c1_ext[IDX_W-1:0];
    assign last_idx   = IDX_W'(r_cnt - 1'b1);
    assign full       = (r_cnt == CNT_W'(CAPACITY));
    assign rem_inside = (CNT_W'(r_i) < r_cnt);
    assign due_stop   = (r_n == OUT_CNT_W'(MAX_OUT)) || (r_cnt == '0);
    assign can_emit   = !r_o_valid || i_out_ready;

    // shared comparator operand select
    always_comb begin
        cmp_a = r_elem[TIME_W-1:0];
        cmp_b = rd_t;
        case (r_state)
            S_DN_CK: begin
                cmp_a = rd_t;
                cmp_b = r_ca[TIME_W-1:0];
            end
            S_DN_MV: begin
                cmp_a = r_child[TIME_W-1:0];
                cmp_b = r_elem[TIME_W-1:0];
            end
            S_DUE_CK: begin
                cmp_a = rd_t;
                cmp_b = r_now;
            end
            default: begin
                cmp_a = r_elem[TIME_W-1:0];
                cmp_b = rd_t;
            end
        endcase
    end
    assign lt = (cmp_a < cmp_b);

    // new time for change, delay (saturating) and hasten (floored at zero)
    assign base_t = r_found ? r_ftime : r_old;
    assign sum_t  = {1'b0, base_t} + {1'b0, r_time};
    assign diff_t = {1'b0, base_t} - {1'b0, r_time};
    always_comb begin
        case (r_cmd)
            CMD_DELAY:  new_t = sum_t[TIME_W] ? {TIME_W{1'b1}} : sum_t[TIME_W-1:0];
            CMD_HASTEN: new_t = diff_t[TIME_W] ? '0 : diff_t[TIME_W-1:0];
            default:    new_t = r_time;
        endcase
    end

    // where a finished sift leads
    always_comb begin
        if (r_cmd == CMD_RESCHED && !r_inserted) begin
            done_next = S_INS;
        end else if (r_cmd == CMD_RUN_DUE) begin
            done_next = S_DUE_RD;
        end else begin
            done_next = S_EMIT;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_cmd))
                        CMD_INSERT:  n_state = S_INS;
                        CMD_POP:     n_state = (r_cnt == '0) ? S_EMIT : S_POP_RD;
                        CMD_RUN_DUE: n_state = S_DUE_RD;
                        default:     n_state = S_FIND_RD;
                    endcase
                end
            end
            S_FIND_RD:  n_state = (r_scan == r_cnt) ? S_DISPATCH : S_FIND_CK;
            S_FIND_CK:  n_state = (rd_id == r_id) ? S_DISPATCH : S_FIND_RD;
            S_DISPATCH: begin
                case (r_cmd)
                    CMD_REMOVE:  n_state = r_found ? S_REM_RD : S_EMIT;
                    CMD_RESCHED: n_state = r_found ? S_REM_RD : S_INS;
                    default:     n_state = r_found ? S_UP_RD : S_INS;
                endcase
            end
            S_INS:      n_state = full ? done_next : S_UP_RD;
            S_UP_RD: begin
                if (r_i == '0) begin
                    n_state = r_resift ? S_DN_RD0 : done_next;
                end else begin
                    n_state = S_UP_CK;
                end
            end
            S_UP_CK: begin
                if (lt) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = r_resift ? S_DN_RD0 : done_next;
                end
            end
            S_DN_RD0:   n_state = c_ge ? done_next : S_DN_RD1;
            S_DN_RD1:   n_state = S_DN_CK;
            S_DN_CK:    n_state = S_DN_MV;
            S_DN_MV:    n_state = lt ? S_DN_RD0 : done_next;
            S_POP_RD:   n_state = S_POP_LAST;
            S_POP_LAST: n_state = S_POP_ELEM;
            S_POP_ELEM: n_state = S_DN_RD0;
            S_REM_RD:   n_state = S_REM_GO;
            S_REM_GO:   n_state = rem_inside ? S_UP_RD : done_next;
            S_DUE_RD:   n_state = due_stop ? S_EMIT : S_DUE_CK;
            S_DUE_CK: begin
                if (!lt) begin
                    n_state = S_EMIT;
                end else if (r_n == '0 || can_emit) begin
                    n_state = S_POP_ELEM;
                end
            end
            S_EMIT:     n_state = can_emit ? S_IDLE : S_EMIT;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath, ram control and result loading
    always_comb begin
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_time     = r_time;
        n_old      = r_old;
        n_now      = r_now;
        n_cnt      = r_cnt;
        n_scan     = r_scan;
        n_found    = r_found;
        n_ftime    = r_ftime;
        n_elem     = r_elem;
        n_i        = r_i;
        n_resift   = r_resift;
        n_inserted = r_inserted;
        n_ca       = r_ca;
        n_two      = r_two;
        n_child    = r_child;
        n_ci       = r_ci;
        n_res_id   = r_res_id;
        n_res_time = r_res_time;
        n_res_st   = r_res_st;
        n_n        = r_n;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_id     = r_o_id;
        n_o_time   = r_o_time;
        n_o_st     = r_o_st;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = r_i;
        ram_wdata  = r_elem;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = t_cmd'(i_cmd);
                    n_id       = ID_BITS'(i_event_id);
                    n_time     = i_time_value;
                    n_old      = i_event_time_in;
                    n_now      = i_now_time;
                    n_scan     = '0;
                    n_found    = 1'b0;
                    n_inserted = 1'b0;
                    n_n        = '0;
                    n_res_id   = '0;
                    n_res_time = '0;
                    n_res_st   = ST_EMPTY;
                end
            end
            S_FIND_RD: begin
                if (r_scan != r_cnt) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_scan[IDX_W-1:0];
                end
            end
            S_FIND_CK: begin
                if (rd_id == r_id) begin
                    n_found = 1'b1;
                    n_i     = r_scan[IDX_W-1:0];
                    n_ftime = rd_t;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_DISPATCH: begin
                case (r_cmd)
                    CMD_REMOVE: begin
                        n_res_id   = r_id;
                        n_res_time = r_found ? r_ftime : '0;
                        n_res_st   = r_found ? ST_OK : ST_NOT_FOUND;
                    end
                    CMD_RESCHED: begin
                        n_res_id = r_id;
                    end
                    default: begin
                        n_time = new_t;
                        if (r_found) begin
                            n_elem     = {r_id, new_t};
                            n_resift   = 1'b1;
                            n_res_id   = r_id;
                            n_res_time = new_t;
                            n_res_st   = ST_OK;
                        end
                    end
                endcase
            end
            S_INS: begin
                n_inserted = 1'b1;
                n_res_id   = r_id;
                n_res_time = r_time;
                if (full) begin
                    n_res_st = ST_FULL;
                end else begin
                    n_res_st = ST_OK;
                    n_elem   = {r_id, r_time};
                    n_i      = IDX_W'(r_cnt);
                    n_cnt    = r_cnt + 1'b1;
                    n_resift = 1'b0;
                end
            end
            S_UP_RD: begin
                if (r_i == '0) begin
                    ram_we = !r_resift;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = parent;
                end
            end
            S_UP_CK: begin
                if (lt) begin
                    // parent moves down into the hole
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                    n_i       = parent;
                    n_resift  = 1'b0;
                end else begin
                    ram_we = !r_resift;
                end
            end
            S_DN_RD0: begin
                if (c_ge) begin
                    ram_we = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = c_idx;
                end
            end
            S_DN_RD1: begin
                n_ca  = rd;
                n_two = c1_lt;
                if (c1_lt) begin
                    ram_re    = 1'b1;
                    ram_raddr = c1_idx;
                end
            end
            S_DN_CK: begin
                // right child only when strictly earlier than the left
                if (r_two && lt) begin
                    n_child = rd;
                    n_ci    = c1_idx;
                end else begin
                    n_child = r_ca;
                    n_ci    = c_idx;
                end
            end
            S_DN_MV: begin
                ram_we = 1'b1;
                if (lt) begin
                    ram_wdata = r_child;
                    n_i       = r_ci;
                end
            end
            S_POP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            S_POP_LAST: begin
                n_res_id   = rd_id;
                n_res_time = rd_t;
                n_res_st   = ST_OK;
                ram_re     = 1'b1;
                ram_raddr  = last_idx;
                n_cnt      = r_cnt - 1'b1;
            end
            S_POP_ELEM: begin
                n_elem   = rd;
                n_i      = '0;
                n_resift = 1'b0;
            end
            S_REM_RD: begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
                n_cnt     = r_cnt - 1'b1;
            end
            S_REM_GO: begin
                n_elem   = rd;
                n_resift = 1'b1;
            end
            S_DUE_RD: begin
                if (!due_stop) begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end else if (r_n == '0) begin
                    n_res_st = ST_NONE_DUE;
                end
            end
            S_DUE_CK: begin
                if (!lt) begin
                    if (r_n == '0) begin
                        n_res_st = ST_NONE_DUE;
                    end
                end else if (r_n == '0 || can_emit) begin
                    // earlier due event goes out, this one becomes pending
                    if (r_n != '0) begin
                        n_o_valid = 1'b1;
                        n_o_id    = ID_PORT_W'(r_res_id);
                        n_o_time  = r_res_time;
                        n_o_st    = r_res_st;
                        n_o_last  = 1'b0;
                    end
                    n_res_id   = rd_id;
                    n_res_time = rd_t;
                    n_res_st   = ST_OK;
                    n_n        = r_n + 1'b1;
                    n_cnt      = r_cnt - 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = last_idx;
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_o_valid = 1'b1;
                    n_o_id    = ID_PORT_W'(r_res_id);
                    n_o_time  = r_res_time;
                    n_o_st    = r_res_st;
                    n_o_last  = 1'b1;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_time     <= n_time;
        r_old      <= n_old;
        r_now      <= n_now;
        r_scan     <= n_scan;
        r_found    <= n_found;
        r_ftime    <= n_ftime;
        r_elem     <= n_elem;
        r_i        <= n_i;
        r_resift   <= n_resift;
        r_inserted <= n_inserted;
        r_ca       <= n_ca;
        r_two      <= n_two;
        r_child    <= n_child;
        r_ci       <= n_ci;
        r_res_id   <= n_res_id;
        r_res_time <= n_res_time;
        r_res_st   <= n_res_st;
        r_n        <= n_n;
        r_o_id     <= n_o_id;
        r_o_time   <= n_o_time;
        r_o_st     <= n_o_st;
        r_o_last   <= n_o_last;
    end

    // ports
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_out_event_id = r_o_id;
    assign o_event_time   = r_o_time;
    assign o_status       = r_o_st;
    assign o_last         = r_o_last;

    // checks
    `ASSERT_ALWAYS(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CNT_W'(CAPACITY))
    `ASSERT_ALWAYS(a_cnt_step, i_clk, i_rst_n, $past(r_cnt) == r_cnt || r_cnt == $past(r_cnt) + 1'b1 || r_cnt + 1'b1 == $past(r_cnt))
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, r_state == S_EMIT && r_o_valid && !i_out_ready, n_state == S_EMIT)
    `ASSERT_IMPLY(a_run_limit, i_clk, i_rst_n, r_cmd == CMD_RUN_DUE && r_state != S_IDLE, r_n <= OUT_CNT_W'(MAX_OUT))

endmodule

// File: rtl/tehp_ram.sv
// ----------------------------------------------------------------------------
// tehp_ram
// heap slot storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module tehp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
